### hw/rtl/snapid_pkg.sv
// ----------------------------------------------------------------------------
// snapid_pkg
// Shared constants of the single-neuron adaptive PID controller.
// ----------------------------------------------------------------------------
package snapid_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int NUM_REGS   = 7;
    localparam int IDX_WIDTH  = 3;

    localparam logic [IDX_WIDTH-1:0] REG_RATE_PROP   = 3'd0;
    localparam logic [IDX_WIDTH-1:0] REG_RATE_INTEG  = 3'd1;
    localparam logic [IDX_WIDTH-1:0] REG_RATE_DERIV  = 3'd2;
    localparam logic [IDX_WIDTH-1:0] REG_INIT_PROP   = 3'd3;
    localparam logic [IDX_WIDTH-1:0] REG_INIT_INTEG  = 3'd4;
    localparam logic [IDX_WIDTH-1:0] REG_INIT_DERIV  = 3'd5;
    localparam logic [IDX_WIDTH-1:0] REG_NEURON_GAIN = 3'd6;

    localparam longint INIT_WEIGHT_RESET = 6554;
    localparam longint NEURON_GAIN_RESET = 7864;

endpackage

### hw/rtl/single_neuron_adaptive_pid_top.sv
// ----------------------------------------------------------------------------
// single_neuron_adaptive_pid_top
// Single-neuron adaptive PID controller, signed fixed point, iterative datapath.
// ----------------------------------------------------------------------------
// One item (reference, measured, restart) gives one drive value. All products run
// through one shared multiplier under a sequencer, with a one-bit-per-cycle
// restoring divider for the three normalized weights. An item is accepted only in
// idle. The sequencer runs error, difference terms, the update of each weight, the
// sum of magnitudes, one division per weight, the weighted sum, gain and drive, so
// a new item is not taken before the last one is through. The result waits in the
// output register; the next item is accepted while it waits, and its sequence
// holds in the last step until the register is free.
module single_neuron_adaptive_pid_top #(
    parameter int DATA_WIDTH = snapid_pkg::DATA_WIDTH,
    parameter int FRAC_BITS  = snapid_pkg::FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // reference, measured (first in low bits)
    input  logic [2*DATA_WIDTH-1:0]       s_tdata,
    // restart
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // drive
    output logic [DATA_WIDTH-1:0]         m_tdata,
    // saturated
    output logic                          m_tuser,
    input  logic                          cfg_we,
    input  logic [snapid_pkg::IDX_WIDTH-1:0] cfg_index,
    input  logic [DATA_WIDTH-1:0]         cfg_data
);

    localparam int W   = DATA_WIDTH;
    localparam int PW  = 2 * DATA_WIDTH;
    localparam int SW  = DATA_WIDTH + 2;
    localparam int CW  = $clog2(FRAC_BITS + 2);
    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_ERR   = 5'd1;
    localparam logic [4:0] ST_X1    = 5'd2;
    localparam logic [4:0] ST_X3A   = 5'd3;
    localparam logic [4:0] ST_X3B   = 5'd4;
    localparam logic [4:0] ST_M1    = 5'd5;
    localparam logic [4:0] ST_M2    = 5'd6;
    localparam logic [4:0] ST_M3    = 5'd7;
    localparam logic [4:0] ST_WADD  = 5'd8;
    localparam logic [4:0] ST_SUM   = 5'd9;
    localparam logic [4:0] ST_DIV   = 5'd10;
    localparam logic [4:0] ST_NM    = 5'd11;
    localparam logic [4:0] ST_ACC   = 5'd12;
    localparam logic [4:0] ST_GAIN  = 5'd13;
    localparam logic [4:0] ST_DRV   = 5'd14;
    localparam logic [4:0] ST_OUT   = 5'd15;

    logic signed [W-1:0] cfg_reg [snapid_pkg::NUM_REGS];

    logic [4:0]          state_reg, state_next;
    logic [1:0]          k_reg, k_next;
    logic signed [W-1:0] ref_reg, meas_reg;
    logic signed [W-1:0] e_reg, x1_reg, x3_reg, t_reg, acc_reg;
    logic signed [W-1:0] el_reg, ebl_reg, dl_reg;
    logic signed [W-1:0] w_reg [3];
    logic signed [W-1:0] n_reg [3];
    logic                flag_reg;
    logic [SW-1:0]       sabs_reg;
    logic [SW-1:0]       rem_reg;
    logic [FRAC_BITS:0]  q_reg;
    logic [CW-1:0]       cnt_reg;
    logic                out_valid_reg;
    logic [W-1:0]        out_drive_reg;
    logic                out_sat_reg;

    // shared multiplier: a*b >> FRAC_BITS, trunc toward zero, saturated
    logic signed [W-1:0] mul_a, mul_b;
    logic signed [W-1:0] mul_r;
    logic                mul_sat;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] prod_t;
    always_comb
    begin
        prod = PW'(mul_a) * PW'(mul_b);
        if (prod < 0)
            prod_t = -((-prod) >>> FRAC_BITS);
        else
            prod_t = prod >>> FRAC_BITS;
        mul_sat = 1'b0;
        if (prod_t > PW'(VMAX))
        begin
            mul_r = VMAX;
            mul_sat = 1'b1;
        end
        else if (prod_t < PW'(VMIN))
        begin
            mul_r = VMIN;
            mul_sat = 1'b1;
        end
        else
            mul_r = prod_t[W-1:0];
    end

    // adder: a + b + c, saturated; its result is used only for the weight update
    logic signed [W-1:0] add_a, add_b, add_c;
    logic signed [W+2:0] add_s;
    logic signed [W-1:0] add_r;
    logic                add_sat;
    always_comb
    begin
        add_s = (W+3)'(add_a) + (W+3)'(add_b) + (W+3)'(add_c);
        add_sat = 1'b0;
        if (add_s > (W+3)'(VMAX))
        begin
            add_r = VMAX;
            add_sat = 1'b1;
        end
        else if (add_s < (W+3)'(VMIN))
        begin
            add_r = VMIN;
            add_sat = 1'b1;
        end
        else
            add_r = add_s[W-1:0];
    end

    logic signed [W-1:0] wk, rate_k, x_k, nk;
    logic [SW-1:0] wmag;
    logic [SW-1:0] rem_sh;
    always_comb
    begin
        wk = w_reg[k_reg];
        nk = n_reg[k_reg];
        rate_k = cfg_reg[{1'b0, k_reg}];
        unique case (k_reg)
            2'd0:    x_k = x1_reg;
            2'd1:    x_k = e_reg;
            default: x_k = x3_reg;
        endcase
        wmag = wk[W-1] ? SW'(-(SW'(wk))) : SW'(wk);
        rem_sh = {rem_reg[SW-2:0], 1'b0};
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        add_a = '0;
        add_b = '0;
        add_c = '0;
        unique case (state_reg)
            ST_ERR:
            begin
                add_a = ref_reg;
                add_b = -meas_reg;
                add_c = '0;
            end
            ST_X1:
            begin
                add_a = e_reg;
                add_b = -el_reg;
            end
            ST_X3A:
            begin
                add_a = e_reg;
                add_b = ebl_reg;
                add_c = -el_reg;
            end
            ST_X3B:
            begin
                add_a = t_reg;
                add_b = -el_reg;
            end
            ST_M1:
            begin
                mul_a = rate_k;
                mul_b = e_reg;
            end
            ST_M2:
            begin
                mul_a = t_reg;
                mul_b = dl_reg;
            end
            ST_M3:
            begin
                mul_a = t_reg;
                mul_b = x_k;
            end
            ST_WADD:
            begin
                add_a = wk;
                add_b = t_reg;
            end
            ST_NM:
            begin
                mul_a = nk;
                mul_b = x_k;
            end
            ST_GAIN:
            begin
                mul_a = cfg_reg[snapid_pkg::REG_NEURON_GAIN];
                mul_b = acc_reg;
            end
            ST_DRV:
            begin
                add_a = dl_reg;
                add_b = t_reg;
            end
            default:
            begin
            end
        endcase
    end

    // negating VMIN wraps in the adder operands; the error, difference and drive terms
    // instead use the exact W+3-bit sums below, saturated by sat3
    logic signed [W+2:0] x3_exact;
    logic signed [W+2:0] acc_exact;
    logic signed [W+2:0] acc_sum;
    assign x3_exact = (W+3)'(e_reg) - 2 * (W+3)'(el_reg) + (W+3)'(ebl_reg);
    assign acc_exact = (W+3)'(acc_reg);
    assign acc_sum = acc_exact + (W+3)'(mul_r);
    logic signed [W+2:0] err_exact;
    assign err_exact = (W+3)'(ref_reg) - (W+3)'(meas_reg);
    logic signed [W+2:0] x1_exact;
    assign x1_exact = (W+3)'(e_reg) - (W+3)'(el_reg);
    logic signed [W+2:0] drv_exact;
    assign drv_exact = (W+3)'(dl_reg) + (W+3)'(t_reg);

    function automatic logic signed [W-1:0] sat3(input logic signed [W+2:0] v);
        if (v > (W+3)'(VMAX))
            return VMAX;
        else if (v < (W+3)'(VMIN))
            return VMIN;
        else
            return v[W-1:0];
    endfunction

    function automatic logic ovf3(input logic signed [W+2:0] v);
        return (v > (W+3)'(VMAX)) || (v < (W+3)'(VMIN));
    endfunction

    logic accept_in;
    logic out_free;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept_in = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[0] <= '0;
            cfg_reg[1] <= '0;
            cfg_reg[2] <= '0;
            cfg_reg[3] <= W'(snapid_pkg::INIT_WEIGHT_RESET);
            cfg_reg[4] <= W'(snapid_pkg::INIT_WEIGHT_RESET);
            cfg_reg[5] <= W'(snapid_pkg::INIT_WEIGHT_RESET);
            cfg_reg[6] <= W'(snapid_pkg::NEURON_GAIN_RESET);
        end
        else if (cfg_we && cfg_index < snapid_pkg::IDX_WIDTH'(snapid_pkg::NUM_REGS))
            cfg_reg[cfg_index] <= cfg_data;
    end

    always_comb
    begin
        state_next = state_reg;
        k_next = k_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept_in) state_next = ST_ERR;
            ST_ERR:   state_next = ST_X1;
            ST_X1:    state_next = ST_X3A;
            ST_X3A:   state_next = ST_X3B;
            ST_X3B:
            begin
                state_next = ST_M1;
                k_next = 2'd0;
            end
            ST_M1:    state_next = ST_M2;
            ST_M2:    state_next = ST_M3;
            ST_M3:    state_next = ST_WADD;
            ST_WADD:
            begin
                if (k_reg == 2'd2)
                begin
                    state_next = ST_SUM;
                    k_next = 2'd0;
                end
                else
                begin
                    state_next = ST_M1;
                    k_next = k_reg + 2'd1;
                end
            end
            ST_SUM:   state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == CW'(FRAC_BITS + 1))
                begin
                    if (k_reg == 2'd2)
                    begin
                        state_next = ST_NM;
                        k_next = 2'd0;
                    end
                    else
                        k_next = k_reg + 2'd1;
                end
            end
            ST_NM:
            begin
                if (k_reg == 2'd2)
                    state_next = ST_ACC;
                else
                    k_next = k_reg + 2'd1;
            end
            ST_ACC:   state_next = ST_GAIN;
            ST_GAIN:  state_next = ST_DRV;
            ST_DRV:   state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg <= '0;
            out_valid_reg <= 1'b0;
            el_reg <= '0;
            ebl_reg <= '0;
            dl_reg <= '0;
            w_reg[0] <= W'(snapid_pkg::INIT_WEIGHT_RESET);
            w_reg[1] <= W'(snapid_pkg::INIT_WEIGHT_RESET);
            w_reg[2] <= W'(snapid_pkg::INIT_WEIGHT_RESET);
            cnt_reg <= '0;
            flag_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg <= k_next;
            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept_in)
                    begin
                        ref_reg <= s_tdata[W-1:0];
                        meas_reg <= s_tdata[PW-1:W];
                        flag_reg <= 1'b0;
                        if (s_tuser)
                        begin
                            w_reg[0] <= cfg_reg[snapid_pkg::REG_INIT_PROP];
                            w_reg[1] <= cfg_reg[snapid_pkg::REG_INIT_INTEG];
                            w_reg[2] <= cfg_reg[snapid_pkg::REG_INIT_DERIV];
                            el_reg <= '0;
                            ebl_reg <= '0;
                            dl_reg <= '0;
                        end
                    end
                end
                ST_ERR:
                begin
                    e_reg <= sat3(err_exact);
                    flag_reg <= flag_reg | ovf3(err_exact);
                end
                ST_X1:
                begin
                    x1_reg <= sat3(x1_exact);
                    flag_reg <= flag_reg | ovf3(x1_exact);
                end
                ST_X3A:
                begin
                    x3_reg <= sat3(x3_exact);
                    flag_reg <= flag_reg | ovf3(x3_exact);
                end
                ST_X3B:
                begin
                end
                ST_M1, ST_M2, ST_M3:
                begin
                    t_reg <= mul_r;
                    flag_reg <= flag_reg | mul_sat;
                end
                ST_WADD:
                begin
                    w_reg[k_reg] <= add_r;
                    flag_reg <= flag_reg | add_sat;
                end
                ST_SUM:
                begin
                    sabs_reg <= (w_reg[0][W-1] ? SW'(-(SW'(w_reg[0]))) : SW'(w_reg[0]))
                              + (w_reg[1][W-1] ? SW'(-(SW'(w_reg[1]))) : SW'(w_reg[1]))
                              + (w_reg[2][W-1] ? SW'(-(SW'(w_reg[2]))) : SW'(w_reg[2]));
                    cnt_reg <= '0;
                    acc_reg <= '0;
                end
                ST_DIV:
                begin
                    if (cnt_reg == '0)
                    begin
                        // integer bit: set when the sum is nonzero and |w| >= sum
                        if (sabs_reg != '0 && wmag >= sabs_reg)
                        begin
                            q_reg <= (FRAC_BITS+1)'(1);
                            rem_reg <= wmag - sabs_reg;
                        end
                        else
                        begin
                            q_reg <= '0;
                            rem_reg <= wmag;
                        end
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                    else if (cnt_reg == CW'(FRAC_BITS + 1))
                    begin
                        if (sabs_reg == '0)
                            n_reg[k_reg] <= '0;
                        else if (wk[W-1])
                            n_reg[k_reg] <= -W'(q_reg);
                        else
                            n_reg[k_reg] <= W'(q_reg);
                        cnt_reg <= '0;
                    end
                    else
                    begin
                        if (rem_sh >= sabs_reg)
                        begin
                            q_reg <= {q_reg[FRAC_BITS-1:0], 1'b1};
                            rem_reg <= rem_sh - sabs_reg;
                        end
                        else
                        begin
                            q_reg <= {q_reg[FRAC_BITS-1:0], 1'b0};
                            rem_reg <= rem_sh;
                        end
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                ST_NM:
                begin
                    // normalized weights keep the running sum within one step of range
                    acc_reg <= sat3(acc_sum);
                    flag_reg <= flag_reg | mul_sat | ovf3(acc_sum);
                end
                ST_ACC:
                begin
                end
                ST_GAIN:
                begin
                    t_reg <= mul_r;
                    flag_reg <= flag_reg | mul_sat;
                end
                ST_DRV:
                begin
                    t_reg <= sat3(drv_exact);
                    flag_reg <= flag_reg | ovf3(drv_exact);
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_drive_reg <= t_reg;
                        out_sat_reg <= flag_reg;
                        dl_reg <= t_reg;
                        ebl_reg <= el_reg;
                        el_reg <= e_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_drive_reg;
    assign m_tuser  = out_sat_reg;

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("ready while busy");
    a_out_after_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == ST_OUT)
        else $error("result without sequence end");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("result lost");

endmodule
